// File: design/cdrs_pkg.sv
// cdrs_pkg: shared types and constants of the counter delta running stats block.
// Used by counter_delta_running_stats; no dependencies.
package cdrs_pkg;

  localparam int SLOT_W     = 8;
  localparam int VALUE_W    = 48;
  localparam int KIND_W     = 2;
  localparam int MEAN_W     = 64;
  localparam int COUNT_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_RAW   = 2'd0,
    KIND_DELTA = 2'd1,
    KIND_RATE  = 2'd2
  } stat_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_INTERVAL = 2'd0,
    REG_TAIL_ENABLE     = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RATE,
    ST_TAIL,
    ST_MEAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] counter_value;
    logic [KIND_W-1:0]  stat_kind;
    logic               sample_ok;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  out_slot;
    logic [VALUE_W-1:0] stat_value;
    logic               stat_valid;
    logic               wrapped;
    logic [VALUE_W-1:0] max_value;
    logic [VALUE_W-1:0] min_value;
    logic [MEAN_W-1:0]  mean_value;
    logic [COUNT_W-1:0] sample_count;
  } out_word_t;

endpackage

// File: design/counter_delta_running_stats.sv
// counter_delta_running_stats: per-slot raw/delta/rate statistics with max, min, mean.
// Depends on cdrs_pkg, cdrs_ram (slot record store) and cdrs_div (shared divider).
//
//   port group   dir   handshake               word
//   in           in    in_valid_i / in_stall_o  in_word_t
//   out          out   out_valid_o / out_stall_i out_word_t
//   cfg          in    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word at a time: read, evaluate, optional rate divide, tail update, optional
// mean divide, write back. Both divides run on the shared divider, and a word may
// also be held in ST_WRITE by an output stall.
// After reset the record store is cleared, one slot per cycle; in_stall_o
// is high meanwhile. The output register lets the next word in while a result is stalled.
module counter_delta_running_stats import cdrs_pkg::*; #(
  parameter int SLOTS        = 256,
  parameter int COUNTER_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CB     = COUNTER_BITS;
  localparam int MW     = CB + FRAC_W;
  localparam int O_CNT  = 0;
  localparam int O_MEAN = O_CNT + COUNT_W;
  localparam int O_MIN  = O_MEAN + MW;
  localparam int O_MAX  = O_MIN + CB;
  localparam int O_LAST = O_MAX + CB;
  localparam int O_PV   = O_LAST + CB;
  localparam int O_PREV = O_PV + 1;
  localparam int REC_W  = O_PREV + CB;

  state_e state_q, state_d;

  logic [AW-1:0]         clr_q, clr_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic                  slot_ok_q, slot_ok_d;
  logic [CB-1:0]         cur_q, cur_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic                  ok_q, ok_d;
  logic [CB-1:0]         last_q, last_d;
  logic [CB-1:0]         max_q, max_d;
  logic [CB-1:0]         min_q, min_d;
  logic [CB-1:0]         stat_q, stat_d;
  logic [MW-1:0]         mean_q, mean_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic                  valid_q, valid_d;
  logic                  wrap_q, wrap_d;
  logic                  neg_q, neg_d;

  logic [INTERVAL_W-1:0] interval_q;
  logic                  tail_en_q;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_word_q, out_word_d;
  logic                  out_load;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [REC_W-1:0]      ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [REC_W-1:0]      ram_rdata;

  logic                  div_start;
  logic [MW-1:0]         div_dividend;
  logic [COUNT_W-1:0]    div_divisor;
  logic                  div_done;
  logic [MW-1:0]         div_quot;

  logic [CB-1:0]         rd_prev, rd_last, rd_max, rd_min;
  logic                  rd_pv;
  logic [MW-1:0]         rd_mean;
  logic [COUNT_W-1:0]    rd_cnt;
  logic                  rd_v, rd_delta, rd_rate, rd_wrap, rd_to_rate;
  logic [CB-1:0]         rd_stat;

  logic                  in_range;
  logic [INTERVAL_W-1:0] ival;
  logic [MW-1:0]         xq, mean_diff;
  logic                  mean_up;
  logic [COUNT_W-1:0]    n_div;
  logic                  tail_div;

  assign in_range = (32'(in_word_i.slot) < SLOTS);
  assign ival     = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;

  assign rd_prev = ram_rdata[O_PREV +: CB];
  assign rd_pv   = ram_rdata[O_PV];
  assign rd_last = ram_rdata[O_LAST +: CB];
  assign rd_max  = ram_rdata[O_MAX +: CB];
  assign rd_min  = ram_rdata[O_MIN +: CB];
  assign rd_mean = ram_rdata[O_MEAN +: MW];
  assign rd_cnt  = ram_rdata[O_CNT +: COUNT_W];

  always_comb begin
    case (stat_kind_e'(kind_q))
      KIND_DELTA: begin
        rd_delta = 1'b1;
        rd_rate  = 1'b0;
      end
      KIND_RATE: begin
        rd_delta = 1'b1;
        rd_rate  = 1'b1;
      end
      default: begin
        rd_delta = 1'b0;
        rd_rate  = 1'b0;
      end
    endcase
    rd_v       = rd_pv & ok_q;
    rd_wrap    = rd_v & rd_delta & (cur_q < rd_prev);
    if (!rd_delta) begin
      rd_stat = cur_q;
    end else if (cur_q < rd_prev) begin
      rd_stat = rd_last;
    end else begin
      rd_stat = cur_q - rd_prev;
    end
    rd_to_rate = rd_v & rd_rate & ~rd_wrap;
  end

  assign xq        = {stat_q, {FRAC_W{1'b0}}};
  assign mean_up   = (xq >= mean_q);
  assign mean_diff = mean_up ? (xq - mean_q) : (mean_q - xq);
  assign n_div     = (cnt_q == COUNT_SAT) ? COUNT_SAT : (cnt_q + COUNT_W'(1));
  assign tail_div  = valid_q & tail_en_q & (cnt_q != '0);

  assign div_dividend = (state_q == ST_READ) ? MW'(rd_stat) : mean_diff;
  assign div_divisor  = (state_q == ST_READ) ? COUNT_W'(ival) : n_div;

  assign ram_raddr = AW'(in_word_i.slot);
  assign ram_wdata = {cur_q, ok_q, last_q, max_q, min_q, mean_q, cnt_q};

  // control
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = AW'(slot_q);
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = in_range ? ST_READ : ST_WRITE;
        end
      end
      ST_READ: begin
        div_start = rd_to_rate;
        state_d   = rd_to_rate ? ST_RATE : ST_TAIL;
      end
      ST_RATE: begin
        if (div_done) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        div_start = tail_div;
        state_d   = tail_div ? ST_MEAN : ST_WRITE;
      end
      ST_MEAN: begin
        if (div_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we = slot_ok_q;
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    slot_d    = slot_q;
    slot_ok_d = slot_ok_q;
    cur_d     = cur_q;
    kind_d    = kind_q;
    ok_d      = ok_q;
    last_d    = last_q;
    max_d     = max_q;
    min_d     = min_q;
    stat_d    = stat_q;
    mean_d    = mean_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    wrap_d    = wrap_q;
    neg_d     = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          slot_d    = in_word_i.slot;
          slot_ok_d = in_range;
          cur_d     = in_word_i.counter_value[CB-1:0];
          kind_d    = in_word_i.stat_kind;
          ok_d      = in_word_i.sample_ok;
          valid_d   = 1'b0;
          wrap_d    = 1'b0;
        end
      end
      ST_READ: begin
        last_d  = rd_last;
        max_d   = rd_max;
        min_d   = rd_min;
        mean_d  = rd_mean;
        cnt_d   = rd_cnt;
        valid_d = rd_v;
        wrap_d  = rd_wrap;
        stat_d  = rd_stat;
      end
      ST_RATE: begin
        if (div_done) begin
          stat_d = div_quot[CB-1:0];
        end
      end
      ST_TAIL: begin
        if (valid_q) begin
          last_d = stat_q;
          if (cnt_q != COUNT_SAT) begin
            cnt_d = cnt_q + COUNT_W'(1);
          end
          if (tail_en_q) begin
            if (cnt_q == '0) begin
              max_d  = stat_q;
              min_d  = stat_q;
              mean_d = xq;
            end else begin
              if (stat_q > max_q) begin
                max_d = stat_q;
              end
              if (stat_q < min_q) begin
                min_d = stat_q;
              end
              neg_d = ~mean_up;
            end
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_d = neg_q ? (mean_q - div_quot) : (mean_q + div_quot);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word_d          = '0;
    out_word_d.out_slot = slot_q;
    if (slot_ok_q) begin
      out_word_d.stat_value   = valid_q ? VALUE_W'(stat_q) : '0;
      out_word_d.stat_valid   = valid_q;
      out_word_d.wrapped      = wrap_q;
      out_word_d.max_value    = VALUE_W'(max_q);
      out_word_d.min_value    = VALUE_W'(min_q);
      out_word_d.mean_value   = MEAN_W'(mean_q);
      out_word_d.sample_count = cnt_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      interval_q  <= INTERVAL_W'(1);
      tail_en_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SAMPLE_INTERVAL: interval_q <= cfg_data_i[INTERVAL_W-1:0];
          REG_TAIL_ENABLE:     tail_en_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    slot_ok_q <= slot_ok_d;
    cur_q     <= cur_d;
    kind_q    <= kind_d;
    ok_q      <= ok_d;
    last_q    <= last_d;
    max_q     <= max_d;
    min_q     <= min_d;
    stat_q    <= stat_d;
    mean_q    <= mean_d;
    cnt_q     <= cnt_d;
    valid_q   <= valid_d;
    wrap_q    <= wrap_d;
    neg_q     <= neg_d;
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  cdrs_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_we && (state_q == ST_CLEAR) ? {REC_W{1'b0}} : ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cdrs_div #(
    .DW (MW),
    .VW (COUNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

endmodule

// File: design/cdrs_ram.sv
// cdrs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cdrs_div.sv
// cdrs_div: iterative unsigned restoring divider, two quotient bits per cycle.
// No dependencies; the divisor must be nonzero.
module cdrs_div #(
  parameter int DW = 64,
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int PW    = DW + (DW % 2);
  localparam int STEPS = PW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] num_q, num_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [VW-1:0] den_q, den_d;
  logic [VW-1:0] rem_q, rem_d;

  logic [VW:0]   r1, r2, r1s, r2s;
  logic          ge1, ge2;

  always_comb begin
    r1  = {rem_q, num_q[PW-1]};
    ge1 = (r1 >= {1'b0, den_q});
    r1s = ge1 ? (r1 - {1'b0, den_q}) : r1;
    r2  = {r1s[VW-1:0], num_q[PW-2]};
    ge2 = (r2 >= {1'b0, den_q});
    r2s = ge2 ? (r2 - {1'b0, den_q}) : r2;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(STEPS);
      num_d  = PW'(dividend_i);
      quo_d  = '0;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[PW-3:0], 2'b00};
      quo_d = {quo_q[PW-3:0], ge1, ge2};
      rem_d = r2s[VW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DW-1:0];

endmodule
